>>> src/tcfe_pkg.sv
`default_nettype none

package tcfe_pkg;

  localparam int CACHE_DEPTH_DEF = 16;
  localparam int GRID_SIZE_DEF   = 64;

  localparam int TILE_W    = 8;
  localparam int COORD_W   = 6;
  localparam int SLOT_W    = 4;
  localparam int OUTCOME_W = 2;
  localparam int DIST_W    = COORD_W + 1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_REJECT = 2'd0,
    OUT_HIT    = 2'd1,
    OUT_FILL   = 2'd2,
    OUT_EVICT  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // summary of one pass over the slots
  typedef struct packed {
    logic               hit;
    logic               empty_found;
    logic [COORD_W-1:0] victim_col;
    logic [COORD_W-1:0] victim_row;
  } scan_res_t;

endpackage

`default_nettype wire

>>> src/tcfe_tag_mem.sv
`default_nettype none

module tcfe_tag_mem #(
  parameter int CACHE_DEPTH = tcfe_pkg::CACHE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(CACHE_DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [IDX_W-1:0]             wr_addr,
  input  wire logic [tcfe_pkg::COORD_W-1:0] wr_col,
  input  wire logic [tcfe_pkg::COORD_W-1:0] wr_row,
  input  wire logic                         rd_en,
  input  wire logic [IDX_W-1:0]             rd_addr,
  output logic      [tcfe_pkg::COORD_W-1:0] rd_col,
  output logic      [tcfe_pkg::COORD_W-1:0] rd_row
);
  import tcfe_pkg::*;

  logic [2*COORD_W-1:0] mem_r [CACHE_DEPTH];
  logic [2*COORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_col, wr_row};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_col = rd_data_r[2*COORD_W-1:COORD_W];
  assign rd_row = rd_data_r[COORD_W-1:0];

endmodule

`default_nettype wire

>>> src/tcfe_scan_unit.sv
`default_nettype none

module tcfe_scan_unit #(
  parameter int CACHE_DEPTH = tcfe_pkg::CACHE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(CACHE_DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clear,
  input  wire logic                         ev_en,
  input  wire logic [IDX_W-1:0]             ev_idx,
  input  wire logic                         ev_valid,
  input  wire logic [tcfe_pkg::COORD_W-1:0] ent_col,
  input  wire logic [tcfe_pkg::COORD_W-1:0] ent_row,
  input  wire logic [tcfe_pkg::COORD_W-1:0] req_col,
  input  wire logic [tcfe_pkg::COORD_W-1:0] req_row,
  input  wire logic [tcfe_pkg::COORD_W-1:0] ctr_x,
  input  wire logic [tcfe_pkg::COORD_W-1:0] ctr_z,
  output tcfe_pkg::scan_res_t               res,
  output logic      [IDX_W-1:0]             hit_idx,
  output logic      [IDX_W-1:0]             empty_idx,
  output logic      [IDX_W-1:0]             victim_idx
);
  import tcfe_pkg::*;

  logic               hit_r;
  logic               empty_found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [IDX_W-1:0]   empty_idx_r;
  logic [IDX_W-1:0]   victim_idx_r;
  logic [DIST_W-1:0]  best_r;
  logic [COORD_W-1:0] victim_col_r;
  logic [COORD_W-1:0] victim_row_r;

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dz;
  logic [DIST_W-1:0]  man_dist;
  logic               match;
  logic               take_victim;

  // manhattan distance of the entry under evaluation
  always_comb begin
    dx          = (ent_col > ctr_x) ? (ent_col - ctr_x) : (ctr_x - ent_col);
    dz          = (ent_row > ctr_z) ? (ent_row - ctr_z) : (ctr_z - ent_row);
    man_dist    = DIST_W'(dx) + DIST_W'(dz);
    match       = ev_valid && (ent_col == req_col) && (ent_row == req_row);
    // a valid slot 0 always seeds the victim so an all-zero field picks slot 0
    take_victim = ev_valid && ((man_dist > best_r) || (ev_idx == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r         <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (clear) begin
      hit_r         <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (ev_en) begin
      if (match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!ev_valid && !empty_found_r) begin
        empty_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      best_r       <= '0;
      victim_idx_r <= '0;
    end else if (ev_en) begin
      if (match && !hit_r) begin
        hit_idx_r <= ev_idx;
      end
      if (!ev_valid && !empty_found_r) begin
        empty_idx_r <= ev_idx;
      end
      if (take_victim) begin
        best_r       <= man_dist;
        victim_idx_r <= ev_idx;
        victim_col_r <= ent_col;
        victim_row_r <= ent_row;
      end
    end
  end

  assign res.hit         = hit_r;
  assign res.empty_found = empty_found_r;
  assign res.victim_col  = victim_col_r;
  assign res.victim_row  = victim_row_r;
  assign hit_idx         = hit_idx_r;
  assign empty_idx       = empty_idx_r;
  assign victim_idx      = victim_idx_r;

endmodule

`default_nettype wire

>>> src/tile_cache_farthest_eviction.sv
// channel   ports                                         transfer when
// request   in_tile_x/z, in_tile_present, in_center_x/z   start && !busy
// result    out_outcome, out_slot, out_evicted_x/z        out_strobe
//
// a request passes through the scan, drain and finish states before the result strobe;
// the tag memory scan reads one slot per cycle through one read port
// the shared compare/distance unit checks hit, first empty and farthest slot
// rejected requests skip the scan and go straight to the finish state
// busy is low in the strobe cycle, so the next request may transfer there
// rst_n is synchronous; it clears the valid bits at once, no clearing pass
// the receiver cannot stall: each result stands for exactly one cycle
`default_nettype none

module tile_cache_farthest_eviction #(
  parameter int CACHE_DEPTH = tcfe_pkg::CACHE_DEPTH_DEF,
  parameter int GRID_SIZE   = tcfe_pkg::GRID_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [tcfe_pkg::TILE_W-1:0]  in_tile_x,
  input  wire logic signed [tcfe_pkg::TILE_W-1:0]  in_tile_z,
  input  wire logic                           in_tile_present,
  input  wire logic        [tcfe_pkg::COORD_W-1:0] in_center_x,
  input  wire logic        [tcfe_pkg::COORD_W-1:0] in_center_z,
  output logic                                out_strobe,
  output logic      [tcfe_pkg::OUTCOME_W-1:0] out_outcome,
  output logic      [tcfe_pkg::SLOT_W-1:0]    out_slot,
  output logic      [tcfe_pkg::COORD_W-1:0]   out_evicted_x,
  output logic      [tcfe_pkg::COORD_W-1:0]   out_evicted_z
);
  import tcfe_pkg::*;

  localparam int                IDX_W    = $clog2(CACHE_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CACHE_DEPTH - 1);
  localparam logic [TILE_W-1:0] GRID_LIM = TILE_W'(GRID_SIZE);

  // sequencer
  state_t state_r, state_nxt;
  logic   accept;
  logic   rd_en;
  logic   finish;

  // request hold registers
  logic               reject_r;
  logic [COORD_W-1:0] req_col_r;
  logic [COORD_W-1:0] req_row_r;
  logic [COORD_W-1:0] ctr_x_r;
  logic [COORD_W-1:0] ctr_z_r;

  // scan pointers
  logic [IDX_W-1:0] rd_idx_r;
  logic             ev_vld_r;
  logic [IDX_W-1:0] ev_idx_r;

  logic [CACHE_DEPTH-1:0] slot_valid_r;

  logic [COORD_W-1:0] ent_col;
  logic [COORD_W-1:0] ent_row;
  scan_res_t          scan_res;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   empty_idx;
  logic [IDX_W-1:0]   victim_idx;

  logic     in_reject;
  outcome_t fin_outcome;
  logic [IDX_W-1:0]   fin_slot;
  logic [COORD_W-1:0] fin_ex;
  logic [COORD_W-1:0] fin_ez;
  logic               fin_write;
  logic               wr_en;

  // negative coordinates read as 128 or more unsigned, so one compare covers both ends
  assign in_reject = !(($unsigned(in_tile_x) < GRID_LIM) &&
                       ($unsigned(in_tile_z) < GRID_LIM) && in_tile_present);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = in_reject ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy   = (state_r != ST_IDLE);
    accept = start && (state_r == ST_IDLE);
    rd_en  = (state_r == ST_SCAN);
    finish = (state_r == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      reject_r <= 1'b0;
      rd_idx_r <= '0;
      ev_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= rd_en;
      if (accept) begin
        reject_r <= in_reject;
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= IDX_W'(rd_idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= rd_idx_r;
    if (accept) begin
      req_col_r <= in_tile_x[COORD_W-1:0];
      req_row_r <= in_tile_z[COORD_W-1:0];
      ctr_x_r   <= in_center_x;
      ctr_z_r   <= in_center_z;
    end
  end

  tcfe_tag_mem #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_tag_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fin_slot),
    .wr_col  (req_col_r),
    .wr_row  (req_row_r),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_col  (ent_col),
    .rd_row  (ent_row)
  );

  // memory data lands in the cycle after the read, valid bit is read alongside
  tcfe_scan_unit #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_scan_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (accept),
    .ev_en      (ev_vld_r),
    .ev_idx     (ev_idx_r),
    .ev_valid   (slot_valid_r[ev_idx_r]),
    .ent_col    (ent_col),
    .ent_row    (ent_row),
    .req_col    (req_col_r),
    .req_row    (req_row_r),
    .ctr_x      (ctr_x_r),
    .ctr_z      (ctr_z_r),
    .res        (scan_res),
    .hit_idx    (hit_idx),
    .empty_idx  (empty_idx),
    .victim_idx (victim_idx)
  );

  // resolve the pass: hit beats a free slot, a free slot beats eviction
  always_comb begin
    fin_outcome = OUT_REJECT;
    fin_slot    = '0;
    fin_ex      = '0;
    fin_ez      = '0;
    fin_write   = 1'b0;
    priority if (reject_r) begin
      fin_outcome = OUT_REJECT;
    end else if (scan_res.hit) begin
      fin_outcome = OUT_HIT;
      fin_slot    = hit_idx;
    end else if (scan_res.empty_found) begin
      fin_outcome = OUT_FILL;
      fin_slot    = empty_idx;
      fin_write   = 1'b1;
    end else begin
      fin_outcome = OUT_EVICT;
      fin_slot    = victim_idx;
      fin_ex      = scan_res.victim_col;
      fin_ez      = scan_res.victim_row;
      fin_write   = 1'b1;
    end
  end

  assign wr_en = finish && fin_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (wr_en) begin
      slot_valid_r[fin_slot] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_outcome   <= fin_outcome;
      out_slot      <= SLOT_W'(fin_slot);
      out_evicted_x <= fin_ex;
      out_evicted_z <= fin_ez;
    end
  end

  // a result follows only the resolve cycle
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_FINISH))
    else $error("result strobe without a resolve cycle");

  // eviction only happens on a full cache
  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && !reject_r && !scan_res.hit && !scan_res.empty_found) |-> (&slot_valid_r))
    else $error("eviction chosen while a slot is free");

  // a rejected request leaves the tags alone
  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && reject_r) |=> $stable(slot_valid_r))
    else $error("rejected request changed the valid bits");

  // a hit never changes the cache state
  a_hit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && !reject_r && scan_res.hit) |-> !wr_en)
    else $error("hit wrote the tag memory");

endmodule

`default_nettype wire
